### rtl/sccb_pkg.sv
// Shared types, codes and line tables for the SCCB register master.
`default_nettype none

package sccb_pkg;

   // Command codes on req_func
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD    = 1'b1;

   localparam int unsigned HalfWidth  = 16;
   // Gap and pause steps run two half periods, so the tick counter needs one more bit
   localparam int unsigned TickWidth  = HalfWidth + 1;
   localparam logic [7:0]  RESET_DEVICE_ADDRESS = 8'd66;
   localparam logic [HalfWidth-1:0] RESET_HALF_PERIOD = 16'd50;
   localparam logic [7:0]  READ_BIT   = 8'h01;

   typedef enum logic [17:0] {
      PH_IDLE   = 18'h00001,
      PH_ST_A   = 18'h00002,
      PH_ST_B   = 18'h00004,
      PH_BIT_LO = 18'h00008,
      PH_BIT_HI = 18'h00010,
      PH_ACK_LO = 18'h00020,
      PH_ACK_HI = 18'h00040,
      PH_GAP    = 18'h00080,
      PH_SP_A   = 18'h00100,
      PH_SP_B   = 18'h00200,
      PH_SP_C   = 18'h00400,
      PH_PAUSE  = 18'h00800,
      PH_RD_LO  = 18'h01000,
      PH_RD_HI  = 18'h02000,
      PH_NA_A   = 18'h04000,
      PH_NA_B   = 18'h08000,
      PH_NA_C   = 18'h10000,
      PH_NA_D   = 18'h20000
   } phase_type;

   function automatic logic scl_of(input phase_type ph);
      logic v;
      case (ph)
         PH_BIT_LO, PH_ACK_LO, PH_GAP, PH_SP_A, PH_RD_LO,
         PH_NA_A, PH_NA_C, PH_NA_D: v = 1'b0;
         default: v = 1'b1;
      endcase
      return v;
   endfunction

   function automatic logic drive_of(input phase_type ph);
      logic v;
      case (ph)
         PH_ACK_LO, PH_ACK_HI, PH_RD_LO, PH_RD_HI: v = 1'b0;
         default: v = 1'b1;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/sccb_register_master_unit.sv
// A word accepted at an edge has its result word in the result register from that edge on,
// so the receiver can take it at the next edge. Throughput: one word per cycle while the
// result register is not held by rsp_stall; the next word is taken while it is drained.
// Each word is one bus tick; the sequencer state and the result register update together.
// Reset (synchronous, active high): sequencer idle, SDA latch set high, flags and
// received byte cleared, device address 66, half period 50.
`default_nettype none

module sccb_register_master_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [sccb_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sccb_pkg::HalfWidth-1:0]     csr_wdata,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_reg_addr,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_sda_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_scl,
   output      logic        rsp_sda_out,
   output      logic        rsp_sda_drive,
   output      logic        rsp_busy_res,
   output      logic        rsp_done_res,
   output      logic [7:0]  rsp_read_data,
   output      logic        rsp_ack_fail
);

   sccb_pkg::phase_type phase_ff, phase_in;
   logic [sccb_pkg::TickWidth-1:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [1:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;
   logic       op_ff, op_in;
   logic [7:0] lreg_ff, lreg_in;
   logic [7:0] ldata_ff, ldata_in;
   logic       fail_ff, fail_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic       latch_ff, latch_in;
   logic [7:0] dev_ff;
   logic [sccb_pkg::HalfWidth-1:0] half_ff;

   logic       rsp_valid_ff;
   logic       scl_ff, sdo_ff, drv_ff, busy_ff, done_ff;

   logic       accept;
   logic       cur_scl, cur_sdo, cur_drv, cur_busy, done_in, entered;
   logic [sccb_pkg::TickWidth-1:0] step_len, tick_next;
   logic [sccb_pkg::HalfWidth-1:0] half_eff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign half_eff = (half_ff == '0) ? {{(sccb_pkg::HalfWidth-1){1'b0}}, 1'b1} : half_ff;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      shift_in = shift_ff;
      op_in    = op_ff;
      lreg_in  = lreg_ff;
      ldata_in = ldata_ff;
      fail_in  = fail_ff;
      rbyte_in = rbyte_ff;
      latch_in = latch_ff;
      done_in  = 1'b0;
      entered  = 1'b0;
      step_len = '0;
      tick_next = '0;

      // start a command only from idle
      if (phase_ff == sccb_pkg::PH_IDLE &&
          (req_func == sccb_pkg::FUNC_WRITE || req_func == sccb_pkg::FUNC_READ)) begin
         op_in    = (req_func == sccb_pkg::FUNC_READ);
         lreg_in  = req_reg_addr;
         ldata_in = req_write_data;
         byte_in  = 2'd0;
         bit_in   = 4'd0;
         if (req_func == sccb_pkg::FUNC_WRITE) begin
            fail_in = 1'b0;
         end
         phase_in = sccb_pkg::PH_ST_A;
         tick_in  = '0;
         latch_in = 1'b1;
      end

      cur_scl  = sccb_pkg::scl_of(phase_in);
      cur_drv  = sccb_pkg::drive_of(phase_in);
      cur_sdo  = latch_in;
      cur_busy = (phase_in != sccb_pkg::PH_IDLE);

      if (cur_busy) begin
         if (phase_in == sccb_pkg::PH_GAP || phase_in == sccb_pkg::PH_PAUSE) begin
            step_len = {half_eff, 1'b0};
         end else begin
            step_len = {1'b0, half_eff};
         end
         tick_next = tick_in + 1'b1;
         if (phase_in == sccb_pkg::PH_RD_HI && tick_in == '0) begin
            shift_in = {shift_in[6:0], req_sda_in};
         end
         if (phase_in == sccb_pkg::PH_ACK_HI && tick_next >= step_len && !op_in && req_sda_in) begin
            fail_in = 1'b1;
         end
         tick_in = tick_next;
         if (tick_next >= step_len) begin
            entered = 1'b1;
            case (phase_in)
               sccb_pkg::PH_ST_A: phase_in = sccb_pkg::PH_ST_B;
               sccb_pkg::PH_ST_B: begin
                  // first frame sends the write address, the repeated start the read address
                  if (byte_in == 2'd0) begin
                     shift_in = dev_ff;
                  end else if (byte_in == 2'd1) begin
                     shift_in = lreg_in;
                  end else if (op_in) begin
                     shift_in = dev_ff | sccb_pkg::READ_BIT;
                  end else begin
                     shift_in = ldata_in;
                  end
                  bit_in   = 4'd0;
                  phase_in = sccb_pkg::PH_BIT_LO;
               end
               sccb_pkg::PH_BIT_LO: phase_in = sccb_pkg::PH_BIT_HI;
               sccb_pkg::PH_BIT_HI: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  phase_in = (bit_in >= 4'd8) ? sccb_pkg::PH_ACK_LO : sccb_pkg::PH_BIT_LO;
               end
               sccb_pkg::PH_ACK_LO: phase_in = sccb_pkg::PH_ACK_HI;
               sccb_pkg::PH_ACK_HI: begin
                  phase_in = (!op_in && byte_in >= 2'd2) ? sccb_pkg::PH_SP_A : sccb_pkg::PH_GAP;
               end
               sccb_pkg::PH_GAP: begin
                  if (op_in && byte_in == 2'd1) begin
                     phase_in = sccb_pkg::PH_SP_A;
                  end else if (op_in && byte_in >= 2'd2) begin
                     byte_in  = 2'd3;
                     bit_in   = 4'd0;
                     shift_in = 8'd0;
                     phase_in = sccb_pkg::PH_RD_LO;
                  end else begin
                     // load the next byte of the frame
                     byte_in = byte_in + 2'd1;
                     if (byte_in == 2'd0) begin
                        shift_in = dev_ff;
                     end else if (byte_in == 2'd1) begin
                        shift_in = lreg_in;
                     end else if (op_in) begin
                        shift_in = dev_ff | sccb_pkg::READ_BIT;
                     end else begin
                        shift_in = ldata_in;
                     end
                     bit_in   = 4'd0;
                     phase_in = sccb_pkg::PH_BIT_LO;
                  end
               end
               sccb_pkg::PH_RD_LO: phase_in = sccb_pkg::PH_RD_HI;
               sccb_pkg::PH_RD_HI: begin
                  bit_in = bit_in + 4'd1;
                  if (bit_in >= 4'd8) begin
                     rbyte_in = shift_in;
                     phase_in = sccb_pkg::PH_NA_A;
                  end else begin
                     phase_in = sccb_pkg::PH_RD_LO;
                  end
               end
               sccb_pkg::PH_NA_A: phase_in = sccb_pkg::PH_NA_B;
               sccb_pkg::PH_NA_B: phase_in = sccb_pkg::PH_NA_C;
               sccb_pkg::PH_NA_C: phase_in = sccb_pkg::PH_NA_D;
               sccb_pkg::PH_NA_D: phase_in = sccb_pkg::PH_SP_A;
               sccb_pkg::PH_SP_A: phase_in = sccb_pkg::PH_SP_B;
               sccb_pkg::PH_SP_B: phase_in = sccb_pkg::PH_SP_C;
               sccb_pkg::PH_SP_C: begin
                  if (op_in && byte_in == 2'd1) begin
                     phase_in = sccb_pkg::PH_PAUSE;
                  end else begin
                     phase_in = sccb_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end
               end
               sccb_pkg::PH_PAUSE: begin
                  byte_in  = 2'd2;
                  phase_in = sccb_pkg::PH_ST_A;
               end
               default: phase_in = sccb_pkg::PH_IDLE;
            endcase
         end
      end else if (phase_in != sccb_pkg::PH_IDLE) begin
         phase_in = sccb_pkg::PH_IDLE;
         tick_in  = '0;
      end

      if (entered) begin
         tick_in = '0;
         case (phase_in)
            sccb_pkg::PH_ST_A, sccb_pkg::PH_SP_C, sccb_pkg::PH_NA_B: latch_in = 1'b1;
            sccb_pkg::PH_ST_B, sccb_pkg::PH_SP_A, sccb_pkg::PH_NA_D: latch_in = 1'b0;
            sccb_pkg::PH_BIT_LO: latch_in = shift_in[7];
            default: latch_in = latch_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff  <= sccb_pkg::RESET_DEVICE_ADDRESS;
         half_ff <= sccb_pkg::RESET_HALF_PERIOD;
      end else if (csr_wr_en) begin
         case (csr_index)
            sccb_pkg::CSR_DEVICE_ADDRESS: dev_ff  <= csr_wdata[7:0];
            sccb_pkg::CSR_HALF_PERIOD:    half_ff <= csr_wdata;
            default: dev_ff <= dev_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sccb_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         op_ff    <= 1'b0;
         lreg_ff  <= '0;
         ldata_ff <= '0;
         fail_ff  <= 1'b0;
         rbyte_ff <= '0;
         latch_ff <= 1'b1;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         op_ff    <= op_in;
         lreg_ff  <= lreg_in;
         ldata_ff <= ldata_in;
         fail_ff  <= fail_in;
         rbyte_ff <= rbyte_in;
         latch_ff <= latch_in;
      end
   end

   // result word register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff        <= cur_scl;
         sdo_ff        <= cur_sdo;
         drv_ff        <= cur_drv;
         busy_ff       <= cur_busy;
         done_ff       <= done_in;
         rsp_read_data <= rbyte_in;
         rsp_ack_fail  <= fail_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = scl_ff;
   assign rsp_sda_out   = sdo_ff;
   assign rsp_sda_drive = drv_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;

`ifndef SYNTHESIS
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl && rsp_sda_drive)
      else $error("bus lines not released while idle");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sccb_pkg::PH_IDLE |-> tick_ff == '0)
      else $error("tick counter running while idle");

   a_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == sccb_pkg::PH_IDLE && req_func == sccb_pkg::FUNC_WRITE
      |=> rsp_valid && rsp_busy_res && !rsp_ack_fail)
      else $error("write command did not start");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("sequencer moved without a word");
`endif

endmodule

`default_nettype wire

### tb/sccb_register_master_unit_test.sv
// Self-checking testbench for the SCCB register master: predicts bus line levels per tick.
`default_nettype none

module sccb_register_master_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD = 8;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
   localparam int          LONG_HOLD    = 90;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
      logic       ack_fail;
   } line_word_type;

   // Tracks the sequencer tick by tick and holds the line levels still to be seen.
   class sccb_line_checker_type;
      logic [7:0]  dev_addr;
      logic [15:0] half;
      sccb_pkg::phase_type ph;
      int unsigned ticks;
      logic [3:0]  bits;
      logic [2:0]  byte_idx;
      logic [7:0]  shifter;
      logic        is_read;
      logic [7:0]  reg_latch;
      logic [7:0]  data_latch;
      logic        ack_bad;
      logic [7:0]  rx_byte;
      logic        sda_level;
      line_word_type levels_due[$];
      int          errors;

      function new();
         dev_addr   = sccb_pkg::RESET_DEVICE_ADDRESS;
         half       = sccb_pkg::RESET_HALF_PERIOD;
         ph         = sccb_pkg::PH_IDLE;
         ticks      = 0;
         bits       = '0;
         byte_idx   = '0;
         shifter    = '0;
         is_read    = 1'b0;
         reg_latch  = '0;
         data_latch = '0;
         ack_bad    = 1'b0;
         rx_byte    = '0;
         sda_level  = 1'b1;
         errors     = 0;
      endfunction

      function bit idle();
         return ph == sccb_pkg::PH_IDLE;
      endfunction

      function int pending();
         return levels_due.size();
      endfunction

      function int unsigned span();
         int unsigned h;
         h = (half == 0) ? 1 : half;
         return (ph == sccb_pkg::PH_GAP || ph == sccb_pkg::PH_PAUSE) ? 2 * h : h;
      endfunction

      function void enter_phase(input sccb_pkg::phase_type p);
         ph    = p;
         ticks = 0;
         case (p)
            sccb_pkg::PH_ST_A, sccb_pkg::PH_SP_C, sccb_pkg::PH_NA_B: sda_level = 1'b1;
            sccb_pkg::PH_ST_B, sccb_pkg::PH_SP_A, sccb_pkg::PH_NA_D: sda_level = 1'b0;
            sccb_pkg::PH_BIT_LO:                                     sda_level = shifter[7];
            default: ;
         endcase
      endfunction

      function void load_next_byte();
         case (byte_idx)
            3'd0: shifter = dev_addr;
            3'd1: shifter = reg_latch;
            default: shifter = is_read ? (dev_addr | sccb_pkg::READ_BIT) : data_latch;
         endcase
         bits = '0;
         enter_phase(sccb_pkg::PH_BIT_LO);
      endfunction

      // Step to the next phase; returns 1 when the transaction ends here.
      function bit advance_phase();
         bit fin;
         fin = 1'b0;
         case (ph)
            sccb_pkg::PH_ST_A:   enter_phase(sccb_pkg::PH_ST_B);
            sccb_pkg::PH_ST_B:   load_next_byte();
            sccb_pkg::PH_BIT_LO: enter_phase(sccb_pkg::PH_BIT_HI);
            sccb_pkg::PH_BIT_HI: begin
               shifter = shifter << 1;
               bits++;
               if (bits >= 8) enter_phase(sccb_pkg::PH_ACK_LO);
               else enter_phase(sccb_pkg::PH_BIT_LO);
            end
            sccb_pkg::PH_ACK_LO: enter_phase(sccb_pkg::PH_ACK_HI);
            sccb_pkg::PH_ACK_HI: begin
               if (!is_read && byte_idx >= 2) enter_phase(sccb_pkg::PH_SP_A);
               else enter_phase(sccb_pkg::PH_GAP);
            end
            sccb_pkg::PH_GAP: begin
               if (is_read && byte_idx == 1) begin
                  enter_phase(sccb_pkg::PH_SP_A);
               end else if (is_read && byte_idx >= 2) begin
                  byte_idx = 3'd3;
                  bits     = '0;
                  shifter  = '0;
                  enter_phase(sccb_pkg::PH_RD_LO);
               end else begin
                  byte_idx = byte_idx + 3'd1;
                  load_next_byte();
               end
            end
            sccb_pkg::PH_RD_LO: enter_phase(sccb_pkg::PH_RD_HI);
            sccb_pkg::PH_RD_HI: begin
               bits++;
               if (bits >= 8) begin
                  rx_byte = shifter;
                  enter_phase(sccb_pkg::PH_NA_A);
               end else begin
                  enter_phase(sccb_pkg::PH_RD_LO);
               end
            end
            sccb_pkg::PH_NA_A: enter_phase(sccb_pkg::PH_NA_B);
            sccb_pkg::PH_NA_B: enter_phase(sccb_pkg::PH_NA_C);
            sccb_pkg::PH_NA_C: enter_phase(sccb_pkg::PH_NA_D);
            sccb_pkg::PH_NA_D: enter_phase(sccb_pkg::PH_SP_A);
            sccb_pkg::PH_SP_A: enter_phase(sccb_pkg::PH_SP_B);
            sccb_pkg::PH_SP_B: enter_phase(sccb_pkg::PH_SP_C);
            sccb_pkg::PH_SP_C: begin
               if (is_read && byte_idx == 1) begin
                  enter_phase(sccb_pkg::PH_PAUSE);
               end else begin
                  ph    = sccb_pkg::PH_IDLE;
                  ticks = 0;
                  fin   = 1'b1;
               end
            end
            sccb_pkg::PH_PAUSE: begin
               byte_idx = 3'd2;
               enter_phase(sccb_pkg::PH_ST_A);
            end
            default: begin
               ph    = sccb_pkg::PH_IDLE;
               ticks = 0;
            end
         endcase
         return fin;
      endfunction

      function void note_tick(input logic [1:0] f, input logic [7:0] ra,
                              input logic [7:0] wd, input logic s);
         line_word_type w;
         int unsigned len;
         if (ph == sccb_pkg::PH_IDLE &&
             (f == sccb_pkg::FUNC_WRITE || f == sccb_pkg::FUNC_READ)) begin
            is_read    = (f == sccb_pkg::FUNC_READ);
            reg_latch  = ra;
            data_latch = wd;
            byte_idx   = '0;
            bits       = '0;
            if (!is_read) ack_bad = 1'b0;
            enter_phase(sccb_pkg::PH_ST_A);
         end
         w = '0;
         w.busy    = (ph != sccb_pkg::PH_IDLE);
         w.sda_out = sda_level;
         case (ph)
            sccb_pkg::PH_BIT_LO, sccb_pkg::PH_ACK_LO, sccb_pkg::PH_GAP, sccb_pkg::PH_SP_A,
            sccb_pkg::PH_RD_LO, sccb_pkg::PH_NA_A, sccb_pkg::PH_NA_C,
            sccb_pkg::PH_NA_D: w.scl = 1'b0;
            default:           w.scl = 1'b1;
         endcase
         case (ph)
            sccb_pkg::PH_ACK_LO, sccb_pkg::PH_ACK_HI, sccb_pkg::PH_RD_LO,
            sccb_pkg::PH_RD_HI: w.sda_drive = 1'b0;
            default:            w.sda_drive = 1'b1;
         endcase
         if (w.busy) begin
            len = span();
            // read bits are taken on the first tick high, write acks on the last
            if (ph == sccb_pkg::PH_RD_HI && ticks == 0) shifter = {shifter[6:0], s};
            if (ph == sccb_pkg::PH_ACK_HI && ticks + 1 >= len && !is_read && s) ack_bad = 1'b1;
            ticks++;
            if (ticks >= len) w.done = advance_phase();
         end
         w.read_data = rx_byte;
         w.ack_fail  = ack_bad;
         levels_due.push_back(w);
      endfunction

      function void compare_field(input string name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_levels(input line_word_type got);
         line_word_type want;
         if (levels_due.size() == 0) begin
            errors++;
            $display("%0t: result word with none outstanding, actual %h", $time, got);
            return;
         end
         want = levels_due.pop_front();
         compare_field("scl", want.scl, got.scl);
         compare_field("sda_out", want.sda_out, got.sda_out);
         compare_field("sda_drive", want.sda_drive, got.sda_drive);
         compare_field("busy_res", want.busy, got.busy);
         compare_field("done_res", want.done, got.done);
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("ack_fail", want.ack_fail, got.ack_fail);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [sccb_pkg::CsrIndexWidth-1:0] csr_index;
   logic [sccb_pkg::HalfWidth-1:0]     csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_func;
   logic [7:0] req_reg_addr;
   logic [7:0] req_write_data;
   logic       req_sda_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_scl;
   logic       rsp_sda_out;
   logic       rsp_sda_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_data;
   logic       rsp_ack_fail;

   sccb_line_checker_type board = new();
   bit gaps_on        = 1'b1;
   bit hold_off_armed = 1'b0;
   int sda_pct        = 0;
   int cycles         = 0;

   sccb_register_master_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_fail   (rsp_ack_fail)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int draw_idle();
      if (!gaps_on) return 0;
      return $urandom_range(0, 1) ? 0 : $urandom_range(1, 17);
   endfunction

   function automatic logic sda_bit();
      return $urandom_range(0, 99) < sda_pct;
   endfunction

   task automatic push_word(input logic [1:0] f, input logic [7:0] ra,
                            input logic [7:0] wd, input logic s);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_reg_addr   <= ra;
      req_write_data <= wd;
      req_sda_in     <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_tick(f, ra, wd, s);
   endtask

   task automatic tick_until_idle();
      while (!board.idle())
         push_word(sccb_pkg::FUNC_TICK, 8'($urandom), 8'($urandom), sda_bit());
   endtask

   task automatic run_command(input logic [1:0] f, input logic [7:0] ra,
                              input logic [7:0] wd, input int pct);
      sda_pct = pct;
      push_word(f, ra, wd, sda_bit());
      tick_until_idle();
   endtask

   // Drain all outstanding words, then load both registers.
   task automatic write_bus_setup(input logic [7:0] addr, input logic [15:0] half);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sccb_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= {8'h00, addr};
      @(posedge clock);
      board.dev_addr = addr;
      csr_index <= sccb_pkg::CSR_HALF_PERIOD;
      csr_wdata <= half;
      @(posedge clock);
      board.half = half;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count);
      logic [1:0] f;
      int         k;
      for (int i = 0; i < count; i++) begin
         if (board.idle()) begin
            k = $urandom_range(0, 9);
            if (k < 4) f = sccb_pkg::FUNC_WRITE;
            else if (k < 8) f = sccb_pkg::FUNC_READ;
            else if (k == 8) f = sccb_pkg::FUNC_TICK;
            else f = FUNC_UNUSED;
            if (f == sccb_pkg::FUNC_WRITE || f == sccb_pkg::FUNC_READ) begin
               case ($urandom_range(0, 5))
                  0, 1:    sda_pct = 0;
                  2:       sda_pct = 10;
                  3:       sda_pct = 50;
                  4:       sda_pct = 90;
                  default: sda_pct = 100;
               endcase
            end
         end else begin
            // mostly plain ticks; stray commands must be dropped while busy
            k = $urandom_range(0, 39);
            if (k == 0) f = sccb_pkg::FUNC_WRITE;
            else if (k == 1) f = sccb_pkg::FUNC_READ;
            else if (k == 2) f = FUNC_UNUSED;
            else f = sccb_pkg::FUNC_TICK;
         end
         push_word(f, 8'($urandom), 8'($urandom), sda_bit());
      end
   endtask

   // Result side: check each accepted word, then hold off for a drawn while.
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            board.check_levels('{scl: rsp_scl, sda_out: rsp_sda_out,
                                 sda_drive: rsp_sda_drive, busy: rsp_busy_res,
                                 done: rsp_done_res, read_data: rsp_read_data,
                                 ack_fail: rsp_ack_fail});
            n = draw_idle();
            if (hold_off_armed) begin
               n = LONG_HOLD;
               hold_off_armed = 1'b0;
            end
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= sccb_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_func       <= sccb_pkg::FUNC_TICK;
      req_reg_addr   <= '0;
      req_write_data <= '0;
      req_sda_in     <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: unused code when idle, then stray commands during a write
      push_word(FUNC_UNUSED, 8'hFF, 8'hFF, 1'b1);
      push_word(sccb_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0);
      push_word(sccb_pkg::FUNC_WRITE, 8'hFF, 8'h00, 1'b0);
      push_word(sccb_pkg::FUNC_READ, 8'h00, 8'hFF, 1'b1);
      push_word(FUNC_UNUSED, 8'h5A, 8'hA5, 1'b1);
      repeat (4) push_word(sccb_pkg::FUNC_TICK, 8'($urandom), 8'($urandom), 1'b0);

      write_bus_setup(8'hFE, 16'd1);
      sda_pct = 0;
      tick_until_idle();
      // failed acks, then a read that keeps the flag, then a write that clears it
      run_command(sccb_pkg::FUNC_WRITE, 8'h00, 8'hFF, 100);
      run_command(sccb_pkg::FUNC_READ, 8'h5A, 8'h00, 100);
      run_command(sccb_pkg::FUNC_WRITE, 8'hA5, 8'h5A, 0);
      run_command(sccb_pkg::FUNC_READ, 8'hFF, 8'hFF, 0);
      run_random(300);

      // zero half period acts as one
      write_bus_setup(8'h00, 16'd0);
      run_random(250);

      gaps_on = 1'b0;
      write_bus_setup(8'($urandom_range(0, 127) * 2), 16'd2);
      run_random(350);
      gaps_on = 1'b1;

      write_bus_setup(8'hFF, 16'hFFFF);
      run_random(30);

      write_bus_setup(8'($urandom), 16'd3);
      hold_off_armed = 1'b1;
      run_random(350);

      write_bus_setup(sccb_pkg::RESET_DEVICE_ADDRESS, 16'd1);
      run_random(350);

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
